[hdl/i2cmts_pkg.sv]
// shared types, status codes and sizes of the i2c master transfer sequencer
`default_nettype none

package i2cmts_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int LEN_LIM = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_EVENT = 2'd2;

	localparam logic [1:0] MODE_NOP   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_FLAGS = 2'd1;
	localparam logic [1:0] ACT_ZERO  = 2'd2;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_NOREPLY = 2'd1;
	localparam logic [1:0] RES_BUSY    = 2'd2;

	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK = 8'h48;
	localparam logic [7:0] ST_RX_ACK    = 8'h50;
	localparam logic [7:0] ST_RX_NACK   = 8'h58;
	localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK = 8'h20;
	localparam logic [7:0] ST_TX_ACK    = 8'h28;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] op_mode;
		logic [7:0] slave_address;
		logic [8:0] length;
		logic [7:0] load_index;
		logic [7:0] data_byte;
		logic [7:0] status_code;
		logic       si_flag;
		logic       cur_aa;
		logic       cur_sta;
		logic       cur_sto;
	} in_t;

	typedef struct packed {
		logic [1:0] ctrl_action;
		logic       ctrl_sta;
		logic       ctrl_sto;
		logic       ctrl_aa;
		logic       ctrl_si;
		logic       data_write;
		logic [7:0] data_out;
		logic       rx_valid;
		logic [7:0] rx_index;
		logic [7:0] rx_data;
		logic       done_res;
		logic [1:0] result_code;
	} out_t;

	typedef struct packed {
		logic              wr_en;
		logic [BUF_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [BUF_AW-1:0] rd_addr;
	} mem_req_t;

endpackage

`default_nettype wire

[hdl/i2cmts_txbuf.sv]
// transmit byte buffer, one write and one registered read port
`default_nettype none

module i2cmts_txbuf (
	input  wire logic                clk,
	input  wire i2cmts_pkg::mem_req_t req,
	output logic [7:0]               rdata
);

	logic [7:0] mem [i2cmts_pkg::BUFFER_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/i2cmts_ctrl.sv]
// transfer state registers and status code decode
`default_nettype none

module i2cmts_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire i2cmts_pkg::in_t      item,
	output i2cmts_pkg::out_t          rsp,
	output logic                      buf_sel,
	output i2cmts_pkg::mem_req_t      mreq
);

	logic [1:0] mode_q, mode_d;
	logic [7:0] addr_q, addr_d;
	logic [8:0] len_q, len_d;
	logic [8:0] cnt_q, cnt_d;
	logic       fin;
	logic [8:0] cnt_bump;
	logic       rx_ok;
	logic [8:0] cnt_rx;
	logic [8:0] cnt_tx;
	logic       nsto;
	i2cmts_pkg::mem_req_t req;

	assign cnt_bump = (cnt_q != 9'h1FF) ? 9'(cnt_q + 9'd1) : cnt_q;
	assign rx_ok    = cnt_q < len_q;
	assign cnt_rx   = rx_ok ? cnt_bump : cnt_q;
	assign cnt_tx   = (item.status_code == i2cmts_pkg::ST_TX_ACK) ? cnt_bump : cnt_q;

	always_comb begin
		rsp    = '0;
		req    = '0;
		buf_sel = 1'b0;
		fin    = 1'b0;
		nsto   = item.cur_sto;
		mode_d = mode_q;
		addr_d = addr_q;
		len_d  = len_q;
		cnt_d  = cnt_q;
		case (item.kind)
			i2cmts_pkg::KIND_LOAD: begin
				if (32'(item.load_index) < i2cmts_pkg::BUFFER_DEPTH) begin
					req.wr_en   = 1'b1;
					req.wr_addr = i2cmts_pkg::BUF_AW'(item.load_index);
					req.wr_data = item.data_byte;
				end
			end
			i2cmts_pkg::KIND_START: begin
				mode_d = item.op_mode;
				addr_d = item.slave_address;
				len_d  = (item.length > 9'(i2cmts_pkg::LEN_LIM)) ?
					9'(i2cmts_pkg::LEN_LIM) : item.length;
				cnt_d  = '0;
				rsp.ctrl_action = i2cmts_pkg::ACT_FLAGS;
				rsp.ctrl_sta    = 1'b1;
				rsp.ctrl_sto    = item.cur_sto;
				rsp.ctrl_aa     = 1'b1;
				rsp.ctrl_si     = item.si_flag;
			end
			i2cmts_pkg::KIND_EVENT: begin
				if (item.si_flag) begin
					case (mode_q)
						i2cmts_pkg::MODE_READ: begin
							rsp.ctrl_action = i2cmts_pkg::ACT_FLAGS;
							rsp.ctrl_sta    = item.cur_sta;
							rsp.ctrl_sto    = item.cur_sto;
							rsp.ctrl_aa     = item.cur_aa;
							case (item.status_code)
								i2cmts_pkg::ST_START: begin
									rsp.data_write = 1'b1;
									rsp.data_out   = addr_q;
									rsp.ctrl_sta   = 1'b0;
								end
								i2cmts_pkg::ST_SLAR_ACK: begin
									rsp.ctrl_aa = (10'(cnt_q) + 10'd1) < 10'(len_q);
								end
								i2cmts_pkg::ST_SLAR_NACK: begin
									rsp.ctrl_sto    = 1'b1;
									rsp.result_code = i2cmts_pkg::RES_NOREPLY;
									fin             = 1'b1;
								end
								i2cmts_pkg::ST_RX_ACK: begin
									rsp.rx_valid = rx_ok;
									rsp.rx_index = rx_ok ? cnt_q[7:0] : 8'd0;
									rsp.rx_data  = rx_ok ? item.data_byte : 8'd0;
									cnt_d        = cnt_rx;
									rsp.ctrl_aa  = (10'(cnt_rx) + 10'd1) < 10'(len_q);
								end
								i2cmts_pkg::ST_RX_NACK: begin
									rsp.rx_valid    = rx_ok;
									rsp.rx_index    = rx_ok ? cnt_q[7:0] : 8'd0;
									rsp.rx_data     = rx_ok ? item.data_byte : 8'd0;
									cnt_d           = cnt_rx;
									rsp.ctrl_sto    = 1'b1;
									rsp.ctrl_aa     = 1'b1;
									rsp.result_code = i2cmts_pkg::RES_OK;
									fin             = 1'b1;
								end
								default: begin
									rsp.ctrl_action = i2cmts_pkg::ACT_ZERO;
									rsp.ctrl_sta    = 1'b0;
									rsp.ctrl_sto    = 1'b0;
									rsp.ctrl_aa     = 1'b0;
									rsp.result_code = i2cmts_pkg::RES_BUSY;
									fin             = 1'b1;
								end
							endcase
						end
						i2cmts_pkg::MODE_WRITE: begin
							rsp.ctrl_action = i2cmts_pkg::ACT_FLAGS;
							rsp.ctrl_sta    = item.cur_sta;
							rsp.ctrl_sto    = item.cur_sto;
							rsp.ctrl_aa     = item.cur_aa;
							case (item.status_code)
								i2cmts_pkg::ST_START: begin
									rsp.data_write = 1'b1;
									rsp.data_out   = addr_q;
									rsp.ctrl_sta   = 1'b0;
								end
								i2cmts_pkg::ST_SLAW_ACK, i2cmts_pkg::ST_TX_ACK: begin
									cnt_d = cnt_tx;
									if (item.status_code == i2cmts_pkg::ST_SLAW_ACK) begin
										rsp.ctrl_sta = 1'b0;
									end
									if (cnt_tx < len_q) begin
										rsp.data_write = 1'b1;
										buf_sel        = 1'b1;
										req.rd_en      = 1'b1;
										req.rd_addr    = i2cmts_pkg::BUF_AW'(cnt_tx);
									end else begin
										nsto = 1'b1;
									end
									rsp.ctrl_sto = nsto;
									if (cnt_tx == len_q) begin
										rsp.result_code = i2cmts_pkg::RES_OK;
										fin             = 1'b1;
									end
								end
								i2cmts_pkg::ST_SLAW_NACK: begin
									rsp.ctrl_sto    = 1'b1;
									rsp.result_code = i2cmts_pkg::RES_NOREPLY;
									fin             = 1'b1;
								end
								default: begin
									rsp.ctrl_action = i2cmts_pkg::ACT_ZERO;
									rsp.ctrl_sta    = 1'b0;
									rsp.ctrl_sto    = 1'b0;
									rsp.ctrl_aa     = 1'b0;
									rsp.result_code = i2cmts_pkg::RES_BUSY;
									fin             = 1'b1;
								end
							endcase
						end
						default: begin
							rsp.ctrl_action = i2cmts_pkg::ACT_ZERO;
							rsp.result_code = i2cmts_pkg::RES_OK;
							fin             = 1'b1;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			rsp.done_res = 1'b1;
			addr_d       = '0;
			len_d        = '0;
		end
	end

	always_comb begin
		mreq       = req;
		mreq.wr_en = req.wr_en & accept;
		mreq.rd_en = req.rd_en & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= i2cmts_pkg::MODE_NOP;
			addr_q <= '0;
			len_q  <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			addr_q <= addr_d;
			len_q  <= len_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

`default_nettype wire

[hdl/i2c_master_transfer_sequencer_core.sv]
// top level of the i2c master transfer sequencer
//
// channel | signals                    | payload
// --------+----------------------------+------------------
// req     | req_valid / req_ready      | i2cmts_pkg::in_t
// rsp     | rsp_valid / rsp_ready      | i2cmts_pkg::out_t
//
// one item per cycle if not stalled; each gives one rsp item in the next cycle
// the transmit buffer read happens at the accepting edge, data shows in the rsp stage
// req_ready is low only while a rsp item waits and rsp_ready is low
// arst_n clears the transfer state and the rsp stage; buffer contents are not cleared
`default_nettype none

module i2c_master_transfer_sequencer_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire i2cmts_pkg::in_t  req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output i2cmts_pkg::out_t      rsp
);

	logic                 accept;
	i2cmts_pkg::out_t     rsp_c;
	logic                 buf_sel_c;
	i2cmts_pkg::mem_req_t mreq;
	logic [7:0]           rdata;
	logic                 valid_s1;
	i2cmts_pkg::out_t     rsp_s1;
	logic                 buf_sel_s1;

	assign req_ready = !valid_s1 || rsp_ready;
	assign accept    = req_valid && req_ready;

	i2cmts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (req),
		.rsp     (rsp_c),
		.buf_sel (buf_sel_c),
		.mreq    (mreq)
	);

	i2cmts_txbuf u_txbuf (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1     <= rsp_c;
			buf_sel_s1 <= buf_sel_c;
		end
	end

	always_comb begin
		rsp = rsp_s1;
		if (buf_sel_s1) begin
			rsp.data_out = rdata;
		end
	end

	assign rsp_valid = valid_s1;

endmodule

`default_nettype wire

[hdl/i2cmts_checker.sv]
// port level checks of the i2c master transfer sequencer
`default_nettype none

module i2cmts_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire i2cmts_pkg::in_t  req,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire i2cmts_pkg::out_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp item changed while stalled");

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted item gave no rsp item");

	a_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ctrl_action != i2cmts_pkg::ACT_FLAGS |->
		!rsp.ctrl_sta && !rsp.ctrl_sto && !rsp.ctrl_aa && !rsp.ctrl_si)
		else $error("control bits set without flag write");

	a_side_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.data_write || rsp.data_out == 8'd0) &&
		(rsp.rx_valid || (rsp.rx_index == 8'd0 && rsp.rx_data == 8'd0)) &&
		(rsp.done_res || rsp.result_code == i2cmts_pkg::RES_OK))
		else $error("unused rsp field not zero");

	a_start_flags: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.kind == i2cmts_pkg::KIND_START |=>
		rsp.ctrl_action == i2cmts_pkg::ACT_FLAGS && rsp.ctrl_sta && rsp.ctrl_aa)
		else $error("start item did not request start with ack");

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_checker u_i2cmts_checker (.*);

`default_nettype wire
